/* sv/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, idle while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/cmra_pkg.sv */
`default_nettype none

package cmra_pkg;

  localparam int METRIC_BITS    = 16;
  localparam int IN_METRIC_BITS = 16;
  localparam int NUM_METRICS    = 8;
  localparam int IDX_BITS       = $clog2(NUM_METRICS);
  localparam int FRAC_BITS      = 16;
  localparam int FACTOR_BITS    = FRAC_BITS + 1;
  localparam int ACC_BITS       = METRIC_BITS + FACTOR_BITS + 2;
  localparam int THRESH_BITS    = 16;
  localparam int HEIGHT_BITS    = 16;
  localparam int WIDTH_BITS     = 16;
  localparam int RATE_BITS      = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 17;
  localparam int SAT_BITS  = (IN_METRIC_BITS > METRIC_BITS) ? IN_METRIC_BITS : METRIC_BITS;
  localparam int GATE_BITS = (METRIC_BITS > THRESH_BITS) ? METRIC_BITS : THRESH_BITS;

  localparam logic [METRIC_BITS-1:0] METRIC_MAX = {METRIC_BITS{1'b1}};
  localparam logic [FACTOR_BITS-1:0] FACTOR_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = FACTOR_BITS'(437);
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(6554);
  localparam logic [ACC_BITS-1:0]    ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [IDX_BITS-1:0]    LAST_IDX = IDX_BITS'(NUM_METRICS - 1);

  typedef enum logic [IDX_BITS-1:0] {
    M_ERR   = 3'd0,
    M_ZERO  = 3'd1,
    M_SPAT  = 3'd2,
    M_SPATH = 3'd3,
    M_SPATV = 3'd4,
    M_MAG   = 3'd5,
    M_DIST  = 3'd6,
    M_HORZ  = 3'd7
  } metric_idx_t;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FACTOR    = 2'd0,
    CFG_MAG_MODE  = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_index_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic [IN_METRIC_BITS-1:0] motion_prediction_error;
    logic [IN_METRIC_BITS-1:0] zero_motion_size;
    logic [IN_METRIC_BITS-1:0] spatial_error;
    logic [IN_METRIC_BITS-1:0] spatial_error_horizontal;
    logic [IN_METRIC_BITS-1:0] spatial_error_vertical;
    logic [IN_METRIC_BITS-1:0] motion_magnitude;
    logic [IN_METRIC_BITS-1:0] cluster_distortion;
    logic [IN_METRIC_BITS-1:0] horizontalness;
    logic [HEIGHT_BITS-1:0]    frame_height;
    logic [WIDTH_BITS-1:0]     frame_width;
    logic [RATE_BITS-1:0]      frame_rate_in;
  } in_data_t;

  typedef struct packed {
    logic                   averages_valid;
    logic [METRIC_BITS-1:0] avg_motion_error;
    logic [METRIC_BITS-1:0] avg_zero_motion;
    logic [METRIC_BITS-1:0] avg_spatial;
    logic [METRIC_BITS-1:0] avg_spatial_horizontal;
    logic [METRIC_BITS-1:0] avg_spatial_vertical;
    logic [METRIC_BITS-1:0] avg_magnitude;
    logic [METRIC_BITS-1:0] avg_distortion;
    logic [METRIC_BITS-1:0] avg_horizontalness;
    logic [HEIGHT_BITS-1:0] last_height;
    logic [WIDTH_BITS-1:0]  last_width;
    logic [RATE_BITS-1:0]   last_frame_rate;
  } out_data_t;

  // Per-frame values that ride along with every metric update.
  typedef struct packed {
    logic                   seen;
    logic [HEIGHT_BITS-1:0] height;
    logic [WIDTH_BITS-1:0]  width;
    logic [RATE_BITS-1:0]   rate;
  } meta_t;

  typedef struct packed {
    logic                   en;
    logic [IDX_BITS-1:0]    idx;
    logic [METRIC_BITS-1:0] x;
    logic [FACTOR_BITS-1:0] a;
    logic                   upd;
    logic                   clr;
    meta_t                  meta;
  } upd_req_t;

  typedef struct packed {
    logic                   valid;
    logic [IDX_BITS-1:0]    idx;
    logic [METRIC_BITS-1:0] value;
    meta_t                  meta;
  } upd_rsp_t;

  function automatic logic [METRIC_BITS-1:0] sat_metric(input logic [IN_METRIC_BITS-1:0] v);
    logic [SAT_BITS-1:0] w;
    w = SAT_BITS'(v);
    if (w > SAT_BITS'(METRIC_MAX)) begin
      return METRIC_MAX;
    end
    return METRIC_BITS'(w);
  endfunction

endpackage

`default_nettype wire

/* sv/cmra_update.sv */
`default_nettype none

// Average store and blend unit: read one entry, blend, write it back.
module cmra_update (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmra_pkg::upd_req_t req,
  output cmra_pkg::upd_rsp_t     rsp
);
  import cmra_pkg::*;

  logic [METRIC_BITS-1:0] mem [NUM_METRICS];
  logic [NUM_METRICS-1:0] vld;

  logic                   s_valid;
  logic [IDX_BITS-1:0]    s_idx;
  logic [METRIC_BITS-1:0] s_x;
  logic [FACTOR_BITS-1:0] s_a;
  logic                   s_upd;
  logic                   s_clr;
  meta_t                  s_meta;
  logic                   s_rvld;
  logic [METRIC_BITS-1:0] rdata;

  logic [METRIC_BITS-1:0]     old;
  logic signed [METRIC_BITS:0] diff;
  logic signed [ACC_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0] acc;
  logic [METRIC_BITS-1:0]     blended;
  logic [METRIC_BITS-1:0]     value;
  logic                       we;

  // Entries never written since reset read as zero.
  assign old  = s_rvld ? rdata : '0;
  assign diff = $signed({1'b0, s_x}) - $signed({1'b0, old});
  assign prod = $signed({1'b0, s_a}) * diff;
  assign acc  = $signed(ACC_BITS'({old, {FRAC_BITS{1'b0}}})) + prod + $signed(ROUND_HALF);
  assign blended = acc[FRAC_BITS +: METRIC_BITS];

  always_comb begin
    priority if (s_clr) begin
      value = '0;
    end else if (s_upd) begin
      value = blended;
    end else begin
      value = old;
    end
  end

  assign we = s_valid && (s_upd || s_clr);

  always_ff @(posedge clk) begin
    if (req.en) begin
      rdata <= mem[req.idx];
    end
    if (we) begin
      mem[s_idx] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      vld     <= '0;
    end else begin
      s_valid <= req.en;
      if (we) begin
        vld[s_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      s_idx  <= req.idx;
      s_x    <= req.x;
      s_a    <= req.a;
      s_upd  <= req.upd;
      s_clr  <= req.clr;
      s_meta <= req.meta;
      s_rvld <= vld[req.idx];
    end
  end

  assign rsp.valid = s_valid;
  assign rsp.idx   = s_idx;
  assign rsp.value = value;
  assign rsp.meta  = s_meta;

endmodule

`default_nettype wire

/* sv/content_metric_recursive_averager.sv */
// Recursive (exponential) averager of eight video content metrics. Each
// request either brings one frame (metrics in unsigned Q0.16 plus native
// height, width and rate) or clears all averages. The block answers every
// request with exactly one result: the eight averages, the native values of
// the latest frame (zero after a clear) and averages_valid. A frame is
// worked on one metric per cycle while the sequencer is not held by a
// finished result that cannot leave, because the averages live in one small
// memory with a single read port; a new frame can start as the last metric
// of the previous one is read, and a request is taken into a one-deep input
// buffer while the previous one is still being worked on. Entries of the
// average memory carry valid bits cleared at reset, so there is no clearing
// pass. The configuration registers (factor, magnitude mode, zero-motion
// threshold) may only be written while the block is idle.

`default_nettype none

module content_metric_recursive_averager (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [cmra_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [cmra_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire cmra_pkg::in_data_t                     in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output cmra_pkg::out_data_t                         out_data
);
  import cmra_pkg::*;

  // Configuration registers.
  logic [FACTOR_BITS-1:0] cfg_factor;
  logic                   cfg_mag_mode;
  logic [THRESH_BITS-1:0] cfg_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_factor    <= FACTOR_RESET;
      cfg_mag_mode  <= 1'b0;
      cfg_threshold <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FACTOR:    cfg_factor    <= cfg_wdata[FACTOR_BITS-1:0];
        CFG_MAG_MODE:  cfg_mag_mode  <= cfg_wdata[0];
        CFG_THRESHOLD: cfg_threshold <= cfg_wdata[THRESH_BITS-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // One-deep input buffer: decouples the sender from the sequencer.
  logic     buf_valid;
  in_data_t buf_data;

  // Sequencer: one memory read per cycle unless held, metric index in step.
  logic                active;
  logic [IDX_BITS-1:0] step;
  logic                start;
  logic                read_go;

  // Completion handling toward the output register.
  logic pend;
  logic out_free;
  logic last_compute;
  logic done_now;
  logic hold;
  logic move;

  upd_req_t req;
  upd_rsp_t rsp;

  assign out_free     = !out_valid || !out_stall;
  assign last_compute = rsp.valid && (rsp.idx == LAST_IDX);
  assign done_now     = last_compute || pend;
  // A finished frame that cannot leave yet freezes the sequencer, so the
  // result lanes are not overwritten by the next frame.
  assign hold         = done_now && !out_free;
  assign move         = done_now && out_free;

  assign start    = buf_valid && (!active || step == LAST_IDX) && !hold;
  assign read_go  = active && !hold;
  assign in_stall = buf_valid && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (start) begin
      buf_valid <= in_valid;
    end else if (in_valid && !in_stall) begin
      buf_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      buf_data <= in_data;
    end
  end

  // Frame set-up: saturate inputs, pick the factor, open the gate.
  logic [NUM_METRICS-1:0][METRIC_BITS-1:0] x_start;
  logic [NUM_METRICS-1:0]                  upd_start;
  logic [FACTOR_BITS-1:0]                  a_sat;
  logic [FACTOR_BITS-1:0]                  a_start;
  logic                                    gate;
  logic                                    is_clear;
  meta_t                                   meta_start;
  logic                                    seen;

  always_comb begin
    x_start[M_ERR]   = sat_metric(buf_data.motion_prediction_error);
    x_start[M_ZERO]  = sat_metric(buf_data.zero_motion_size);
    x_start[M_SPAT]  = sat_metric(buf_data.spatial_error);
    x_start[M_SPATH] = sat_metric(buf_data.spatial_error_horizontal);
    x_start[M_SPATV] = sat_metric(buf_data.spatial_error_vertical);
    x_start[M_MAG]   = sat_metric(buf_data.motion_magnitude);
    x_start[M_DIST]  = sat_metric(buf_data.cluster_distortion);
    x_start[M_HORZ]  = sat_metric(buf_data.horizontalness);
  end

  assign is_clear = (buf_data.opcode == OP_CLEAR);
  assign gate     = GATE_BITS'(x_start[M_ZERO]) > GATE_BITS'(cfg_threshold);
  // Factors above one act as one; the first frame after a clear is taken whole.
  assign a_sat    = (cfg_factor > FACTOR_ONE) ? FACTOR_ONE : cfg_factor;
  assign a_start  = seen ? a_sat : FACTOR_ONE;

  always_comb begin
    upd_start          = '1;
    upd_start[M_MAG]   = cfg_mag_mode || gate;
    upd_start[M_DIST]  = gate;
    upd_start[M_HORZ]  = gate;
  end

  always_comb begin
    if (is_clear) begin
      meta_start = '0;
    end else begin
      meta_start.seen   = 1'b1;
      meta_start.height = buf_data.frame_height;
      meta_start.width  = buf_data.frame_width;
      meta_start.rate   = buf_data.frame_rate_in;
    end
  end

  // Working copy of the frame being stepped through.
  logic [NUM_METRICS-1:0][METRIC_BITS-1:0] work_x;
  logic [NUM_METRICS-1:0]                  work_upd;
  logic [FACTOR_BITS-1:0]                  work_a;
  logic                                    work_clr;
  meta_t                                   work_meta;

  always_ff @(posedge clk) begin
    if (start) begin
      work_x    <= x_start;
      work_upd  <= upd_start;
      work_a    <= a_start;
      work_clr  <= is_clear;
      work_meta <= meta_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= '0;
      seen   <= 1'b0;
    end else begin
      if (start) begin
        active <= 1'b1;
        step   <= '0;
        seen   <= !is_clear;
      end else if (read_go) begin
        if (step == LAST_IDX) begin
          active <= 1'b0;
        end else begin
          step <= step + IDX_BITS'(1);
        end
      end
    end
  end

  assign req.en   = read_go;
  assign req.idx  = step;
  assign req.x    = work_x[step];
  assign req.a    = work_a;
  assign req.upd  = work_upd[step];
  assign req.clr  = work_clr;
  assign req.meta = work_meta;

  cmra_update u_update (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Result lanes: collect the updated averages of the current frame.
  logic [NUM_METRICS-1:0][METRIC_BITS-1:0] lanes;
  meta_t                                   res_meta;
  logic [NUM_METRICS-1:0][METRIC_BITS-1:0] avg_res;
  meta_t                                   meta_res;
  out_data_t                               res_data;

  always_ff @(posedge clk) begin
    if (rsp.valid) begin
      lanes[rsp.idx] <= rsp.value;
      res_meta       <= rsp.meta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (move) begin
      pend <= 1'b0;
    end else if (last_compute) begin
      pend <= 1'b1;
    end
  end

  // Bypass the last metric straight from the blend unit.
  always_comb begin
    avg_res  = lanes;
    meta_res = res_meta;
    if (last_compute) begin
      avg_res[LAST_IDX] = rsp.value;
      meta_res          = rsp.meta;
    end
  end

  always_comb begin
    res_data.averages_valid         = meta_res.seen;
    res_data.avg_motion_error       = avg_res[M_ERR];
    res_data.avg_zero_motion        = avg_res[M_ZERO];
    res_data.avg_spatial            = avg_res[M_SPAT];
    res_data.avg_spatial_horizontal = avg_res[M_SPATH];
    res_data.avg_spatial_vertical   = avg_res[M_SPATV];
    res_data.avg_magnitude          = avg_res[M_MAG];
    res_data.avg_distortion         = avg_res[M_DIST];
    res_data.avg_horizontalness     = avg_res[M_HORZ];
    res_data.last_height            = meta_res.height;
    res_data.last_width             = meta_res.width;
    res_data.last_frame_rate        = meta_res.rate;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data <= res_data;
    end
  end

endmodule

`default_nettype wire

/* sv/cmra_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module cmra_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire cmra_pkg::out_data_t out_data
);
  import cmra_pkg::*;

  logic in_take;
  logic out_wait;
  logic out_empty;
  logic out_rest_zero;

  assign in_take   = in_valid && !in_stall;
  assign out_wait  = out_valid && out_stall;
  assign out_empty = out_valid && !out_data.averages_valid;
  // Every field but averages_valid, which sits in the top bit.
  assign out_rest_zero = (out_data[$bits(out_data_t)-2:0] == '0);

  // A stalled result holds.
  `ASSERT_CLKD(a_out_hold, clk, rst, out_wait |=> out_valid && $stable(out_data), "result changed")

  // Nothing comes out right after reset.
  `ASSERT_CLK(a_reset_quiet, clk, rst |=> !out_valid, "result valid right after reset")

  // Empty averages come with every field at zero.
  `ASSERT_CLKD(a_clear_zero, clk, rst, out_empty |-> out_rest_zero, "cleared result carries data")

  // Just after reset no result is valid, and no request was taken while reset was high.
  `ASSERT_CLKD(a_no_early, clk, rst, $past(rst) |-> !out_valid && !$past(in_take), "early result")

endmodule

bind content_metric_recursive_averager cmra_checker u_cmra_checker (.*);

`default_nettype wire

/* bench/cmra_tracker_pkg.sv */
`timescale 1ns / 100ps

package cmra_tracker_pkg;
  import cmra_pkg::*;

  // Running copy of the averages and native values of the block. It also
  // keeps the queue of results that accepted requests still owe.
  class average_tracker;
    logic [FACTOR_BITS-1:0] factor;
    logic                   every_frame_magnitude;
    logic [THRESH_BITS-1:0] threshold;

    logic [METRIC_BITS-1:0] avg [NUM_METRICS];
    logic [HEIGHT_BITS-1:0] height;
    logic [WIDTH_BITS-1:0]  width;
    logic [RATE_BITS-1:0]   rate;
    logic                   seen;

    out_data_t expected_averages[$];
    int        mismatch_count;
    int        results_checked;

    function new();
      factor                = FACTOR_RESET;
      every_frame_magnitude = 1'b0;
      threshold             = THRESH_RESET;
      forget_frames();
      mismatch_count  = 0;
      results_checked = 0;
    endfunction

    function void forget_frames();
      foreach (avg[i]) avg[i] = '0;
      height = '0;
      width  = '0;
      rate   = '0;
      seen   = 1'b0;
    endfunction

    function void write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                 input logic [CFG_DATA_BITS-1:0] value);
      case (index)
        CFG_FACTOR:    factor = value[FACTOR_BITS-1:0];
        CFG_MAG_MODE:  every_frame_magnitude = value[0];
        CFG_THRESHOLD: threshold = value[THRESH_BITS-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    endfunction

    function logic [METRIC_BITS-1:0] limit_metric(input logic [IN_METRIC_BITS-1:0] v);
      return (v > METRIC_MAX) ? METRIC_MAX : METRIC_BITS'(v);
    endfunction

    // (1-a)*avg + a*x with a in Q1.16, rounded half up.
    function logic [METRIC_BITS-1:0] blended(input logic [METRIC_BITS-1:0] old_avg,
                                             input logic [METRIC_BITS-1:0] x,
                                             input longint unsigned a);
      longint unsigned acc;
      acc = (longint'(FACTOR_ONE) - a) * longint'(old_avg) + a * longint'(x)
            + longint'(ROUND_HALF);
      acc = acc >> FRAC_BITS;
      return (acc > longint'(METRIC_MAX)) ? METRIC_MAX : METRIC_BITS'(acc);
    endfunction

    function void take_request(input in_data_t req);
      out_data_t              want;
      logic [METRIC_BITS-1:0] x [NUM_METRICS];
      longint unsigned        a;
      logic                   gate;
      if (req.opcode == OP_CLEAR) begin
        forget_frames();
      end else begin
        x[M_ERR]   = limit_metric(req.motion_prediction_error);
        x[M_ZERO]  = limit_metric(req.zero_motion_size);
        x[M_SPAT]  = limit_metric(req.spatial_error);
        x[M_SPATH] = limit_metric(req.spatial_error_horizontal);
        x[M_SPATV] = limit_metric(req.spatial_error_vertical);
        x[M_MAG]   = limit_metric(req.motion_magnitude);
        x[M_DIST]  = limit_metric(req.cluster_distortion);
        x[M_HORZ]  = limit_metric(req.horizontalness);
        a = (factor > FACTOR_ONE) ? longint'(FACTOR_ONE) : longint'(factor);
        if (!seen) a = longint'(FACTOR_ONE);
        gate = x[M_ZERO] > threshold;
        for (int i = M_ERR; i <= M_SPATV; i++) avg[i] = blended(avg[i], x[i], a);
        if (every_frame_magnitude || gate) avg[M_MAG] = blended(avg[M_MAG], x[M_MAG], a);
        if (gate) begin
          avg[M_DIST] = blended(avg[M_DIST], x[M_DIST], a);
          avg[M_HORZ] = blended(avg[M_HORZ], x[M_HORZ], a);
        end
        height = req.frame_height;
        width  = req.frame_width;
        rate   = req.frame_rate_in;
        seen   = 1'b1;
      end
      want.averages_valid         = seen;
      want.avg_motion_error       = avg[M_ERR];
      want.avg_zero_motion        = avg[M_ZERO];
      want.avg_spatial            = avg[M_SPAT];
      want.avg_spatial_horizontal = avg[M_SPATH];
      want.avg_spatial_vertical   = avg[M_SPATV];
      want.avg_magnitude          = avg[M_MAG];
      want.avg_distortion         = avg[M_DIST];
      want.avg_horizontalness     = avg[M_HORZ];
      want.last_height            = height;
      want.last_width             = width;
      want.last_frame_rate        = rate;
      expected_averages.push_back(want);
    endfunction

    function int pending();
      return expected_averages.size();
    endfunction

    task report(input string msg);
      if (mismatch_count < 50) $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
    endtask

    task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d field %s got 0x%0h expected 0x%0h",
                         results_checked, name, got, want));
    endtask

    task check_averages(input out_data_t got);
      out_data_t want;
      if (expected_averages.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = expected_averages.pop_front();
      compare_field("averages_valid", got.averages_valid, want.averages_valid);
      compare_field("avg_motion_error", got.avg_motion_error, want.avg_motion_error);
      compare_field("avg_zero_motion", got.avg_zero_motion, want.avg_zero_motion);
      compare_field("avg_spatial", got.avg_spatial, want.avg_spatial);
      compare_field("avg_spatial_horizontal", got.avg_spatial_horizontal,
                    want.avg_spatial_horizontal);
      compare_field("avg_spatial_vertical", got.avg_spatial_vertical,
                    want.avg_spatial_vertical);
      compare_field("avg_magnitude", got.avg_magnitude, want.avg_magnitude);
      compare_field("avg_distortion", got.avg_distortion, want.avg_distortion);
      compare_field("avg_horizontalness", got.avg_horizontalness, want.avg_horizontalness);
      compare_field("last_height", got.last_height, want.last_height);
      compare_field("last_width", got.last_width, want.last_width);
      compare_field("last_frame_rate", got.last_frame_rate, want.last_frame_rate);
      results_checked++;
    endtask
  endclass

endpackage

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import cmra_pkg::*;
  import cmra_tracker_pkg::*;

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int PRESSURE_PHASE  = 2;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 30;
  localparam int CYCLE_LIMIT     = 500000;

  // Index with no register behind it; writes there must leave all state alone.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 2'd3;
  // Largest factor the port can carry, well above 1.0.
  localparam logic [FACTOR_BITS-1:0]    FACTOR_TOP   = '1;
  localparam logic [IN_METRIC_BITS-1:0] LEVEL_MAX    = '1;

  logic                      clk;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  in_data_t                  in_data;
  logic                      out_valid;
  logic                      out_stall;
  out_data_t                 out_data;

  average_tracker tracker;
  bit             idling_on;
  int             hold_off_left;
  int             cycle_count;

  content_metric_recursive_averager dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both handshakes at the rising edge. Check the result first so that
  // a request taken on the same edge never pairs with an older result.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) tracker.check_averages(out_data);
      if (in_valid && !in_stall) tracker.take_request(in_data);
    end
  end

  // Hard stop in case the block hangs or drops a result.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Result side: a long hold-off when asked for, otherwise short random stall
  // bursts while idling is on. One stall decision per falling edge.
  initial begin : receiver
    int burst_left;
    burst_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 11) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [IN_METRIC_BITS-1:0] random_metric();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LEVEL_MAX;
      default: return IN_METRIC_BITS'($urandom());
    endcase
  endfunction

  // Zero-motion size within a few steps of the threshold, to hit both sides
  // of the gate and the equal case.
  function automatic logic [IN_METRIC_BITS-1:0] near_threshold();
    int level;
    level = int'(tracker.threshold) + int'($urandom_range(0, 6)) - 3;
    if (level < 0) level = 0;
    if (level > int'(LEVEL_MAX)) level = int'(LEVEL_MAX);
    return IN_METRIC_BITS'(level);
  endfunction

  // Mostly frames with random content; a clear now and then.
  function automatic in_data_t random_request();
    in_data_t r;
    r.opcode                   = ($urandom_range(0, 24) == 0) ? OP_CLEAR : OP_FRAME;
    r.motion_prediction_error  = random_metric();
    r.zero_motion_size         = ($urandom_range(0, 2) == 0) ? near_threshold()
                                                             : random_metric();
    r.spatial_error            = random_metric();
    r.spatial_error_horizontal = random_metric();
    r.spatial_error_vertical   = random_metric();
    r.motion_magnitude         = random_metric();
    r.cluster_distortion       = random_metric();
    r.horizontalness           = random_metric();
    r.frame_height             = HEIGHT_BITS'($urandom());
    r.frame_width              = WIDTH_BITS'($urandom());
    r.frame_rate_in            = RATE_BITS'($urandom());
    return r;
  endfunction

  // Clear with random payload in the fields the block should ignore.
  function automatic in_data_t clear_request();
    in_data_t r;
    r        = random_request();
    r.opcode = OP_CLEAR;
    return r;
  endfunction

  // Every metric but zero-motion size at one level, native values all zero or all ones.
  function automatic in_data_t flat_frame(input logic [IN_METRIC_BITS-1:0] level,
                                          input logic [IN_METRIC_BITS-1:0] zero_motion,
                                          input bit native_max);
    in_data_t r;
    r.opcode                   = OP_FRAME;
    r.motion_prediction_error  = level;
    r.zero_motion_size         = zero_motion;
    r.spatial_error            = level;
    r.spatial_error_horizontal = level;
    r.spatial_error_vertical   = level;
    r.motion_magnitude         = level;
    r.cluster_distortion       = level;
    r.horizontalness           = level;
    r.frame_height             = native_max ? '1 : '0;
    r.frame_width              = native_max ? '1 : '0;
    r.frame_rate_in            = native_max ? '1 : '0;
    return r;
  endfunction

  // Offer one request, called at a falling edge; return at the falling edge
  // after it was taken. Valid stays high so the next call can go on without
  // a gap; hold the payload steady while the block stalls.
  task automatic send_request(input in_data_t req);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait until every result owed has come back.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Leave the write enable high; set_config lowers it after the last write.
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.write_register(index, value);
    @(negedge clk);
  endtask

  // Write all registers plus a stray write to the unmapped index. Unused
  // upper data bits carry noise that the block must mask off.
  task automatic set_config(input logic [FACTOR_BITS-1:0] factor,
                            input logic mode,
                            input logic [THRESH_BITS-1:0] threshold);
    write_register(CFG_FACTOR, CFG_DATA_BITS'(factor));
    write_register(CFG_MAG_MODE, {(CFG_DATA_BITS-1)'($urandom()), mode});
    write_register(CFG_UNMAPPED, CFG_DATA_BITS'($urandom()));
    write_register(CFG_THRESHOLD,
                   {(CFG_DATA_BITS-THRESH_BITS)'($urandom()), threshold});
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    logic [FACTOR_BITS-1:0] factor;
    logic [THRESH_BITS-1:0] threshold;
    logic                   mode;

    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_data       = '0;
    idling_on     = 1'b1;
    hold_off_left = 0;
    cycle_count   = 0;
    tracker       = new();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: slow factor, gated magnitude, threshold near 0.1.
    send_request(clear_request());                         // clear before any frame
    send_request(flat_frame(LEVEL_MAX, LEVEL_MAX, 1'b1));  // first frame taken as is
    send_request(flat_frame('0, '0, 1'b0));                // gate closed, gated hold
    send_request(flat_frame(LEVEL_MAX, THRESH_RESET, 1'b1)); // equal: still closed
    send_request(flat_frame(LEVEL_MAX, THRESH_RESET + 1'b1, 1'b0)); // just open
    send_request(clear_request());
    send_request(flat_frame(LEVEL_MAX, '0, 1'b1));         // first frame, gate closed
    send_request(clear_request());
    send_request(clear_request());                         // clear on empty state
    finish_phase();

    // Factor exactly one, magnitude on every frame, zero threshold.
    set_config(FACTOR_ONE, 1'b1, '0);
    send_request(flat_frame(LEVEL_MAX, '0, 1'b1));
    send_request(flat_frame('0, '0, 1'b0));
    send_request(flat_frame(IN_METRIC_BITS'(16'h1234), 16'd1, 1'b1));
    finish_phase();

    // Factor above one saturates; top threshold keeps the gate shut.
    set_config(FACTOR_TOP, 1'b0, '1);
    send_request(flat_frame('0, LEVEL_MAX, 1'b0));
    send_request(flat_frame(LEVEL_MAX, LEVEL_MAX, 1'b1));
    send_request(random_request());
    finish_phase();

    // Zero factor freezes the averages once the first frame is in.
    set_config('0, 1'b1, THRESH_BITS'(32768));
    send_request(flat_frame(LEVEL_MAX, LEVEL_MAX, 1'b1));
    send_request(flat_frame('0, '0, 1'b0));
    send_request(clear_request());
    send_request(flat_frame(IN_METRIC_BITS'(12345), IN_METRIC_BITS'(40000), 1'b0));
    send_request(flat_frame(LEVEL_MAX, LEVEL_MAX, 1'b1));

    // Random phases, each under its own settings. Favor the factor and
    // threshold extremes; the last phase runs with no idling at all.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      finish_phase();
      case ($urandom_range(0, 5))
        0:       factor = '0;
        1:       factor = FACTOR_ONE;
        2:       factor = FACTOR_BITS'($urandom_range(int'(FACTOR_ONE) + 1,
                                                      int'(FACTOR_TOP)));
        3:       factor = FACTOR_BITS'($urandom_range(1, 1000));
        default: factor = FACTOR_BITS'($urandom_range(0, int'(FACTOR_ONE)));
      endcase
      case ($urandom_range(0, 3))
        0:       threshold = '0;
        1:       threshold = '1;
        default: threshold = THRESH_BITS'($urandom());
      endcase
      mode = 1'($urandom());
      set_config(factor, mode, threshold);
      idling_on = (phase != RANDOM_PHASES - 1);
      // Hold the result side off for a long stretch while requests keep
      // coming, so the block fills and stalls its input.
      if (phase == PRESSURE_PHASE) hold_off_left = HOLD_OFF_CYCLES;
      repeat (ITEMS_PER_PHASE) send_request(random_request());
    end
    finish_phase();

    // Let any stray late result show up before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/cmra_pkg.sv
sv/cmra_update.sv
sv/content_metric_recursive_averager.sv
sv/cmra_checker.sv
bench/cmra_tracker_pkg.sv
bench/tb_top.sv
